// ===== sv/nearest_timestamp_matcher_top_defines.svh =====
// assertion macros used by the matcher datapath
`ifndef NEAREST_TIMESTAMP_MATCHER_TOP_DEFINES_SVH
`define NEAREST_TIMESTAMP_MATCHER_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define NTM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define NTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ntm_pkg.sv =====
// shared constants, types and helpers of the nearest timestamp matcher
package ntm_pkg;

    localparam int DEPTH     = 16;
    localparam int HANDLE_W  = 32;
    localparam int STAMP_W   = 63;
    localparam int OFFS_W    = 64;
    localparam int OCC_W     = 5;
    localparam int LIMIT_W   = 5;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;
    localparam int RING      = DEPTH + 1;
    localparam int PTR_W     = $clog2(RING);
    localparam int CNT_W     = $clog2(DEPTH + 2);
    localparam int SUM_W     = $clog2(2 * RING);
    localparam int WORD_W    = STAMP_W + HANDLE_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_MATCH = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT      = 2'd0,
        CFG_MAX_OFFSET = 2'd1,
        CFG_SORTED     = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RD_FIND,
        RD_SHIFT,
        RD_MATCH
    } t_rd_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_FIND_DRAIN,
        ST_SHIFT,
        ST_SHIFT_DRAIN,
        ST_INSERT,
        ST_CLEAR,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic     load;
        logic     clear;
        logic     to_count;
        logic     rd_fwd;
        logic     rd_back;
        t_rd_kind rd_kind;
        logic     insert;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic sorted;
        logic k_lt_count;
        logic k_gt_pos;
        logic found;
        logic busy;
        logic out_busy;
    } t_status;

    function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] base,
                                                  logic [CNT_W-1:0] ofs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(ofs);
        if (sum >= SUM_W'(RING)) begin
            sum = sum - SUM_W'(RING);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ===== sv/ntm_ctrl.sv =====
// sequencing state machine of the nearest timestamp matcher
module ntm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [ntm_pkg::OP_W-1:0]    i_op,
    output logic                        o_in_ready,
    input  ntm_pkg::t_status            i_status,
    output ntm_pkg::t_cmd               o_cmd
);
    import ntm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_op)
                        OP_PUSH:  n_state = ST_FIND;
                        OP_MATCH: n_state = ST_SCAN;
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FIND: begin
                if (!(i_status.sorted && i_status.k_lt_count && !i_status.found)) begin
                    n_state = ST_FIND_DRAIN;
                end
            end
            ST_FIND_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (!i_status.k_gt_pos) begin
                    n_state = ST_SHIFT_DRAIN;
                end
            end
            ST_SHIFT_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: n_state = ST_IDLE;
            ST_CLEAR:  n_state = ST_IDLE;
            ST_SCAN: begin
                if (!i_status.k_lt_count) begin
                    n_state = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_status.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_FIND: begin
                if (i_status.sorted && i_status.k_lt_count && !i_status.found) begin
                    o_cmd.rd_fwd  = 1'b1;
                    o_cmd.rd_kind = RD_FIND;
                end
            end
            ST_FIND_DRAIN: o_cmd.to_count = !i_status.busy;
            ST_SHIFT: begin
                if (i_status.k_gt_pos) begin
                    o_cmd.rd_back = 1'b1;
                    o_cmd.rd_kind = RD_SHIFT;
                end
            end
            ST_INSERT: o_cmd.insert = 1'b1;
            ST_CLEAR:  o_cmd.clear  = 1'b1;
            ST_SCAN: begin
                if (i_status.k_lt_count) begin
                    o_cmd.rd_fwd  = 1'b1;
                    o_cmd.rd_kind = RD_MATCH;
                end
            end
            ST_OUT: o_cmd.out_load = !i_status.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/ntm_datapath.sv =====
// frame ring buffer, search pipeline, config and result registers
`include "nearest_timestamp_matcher_top_defines.svh"

module ntm_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ntm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ntm_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic [ntm_pkg::STAMP_W-1:0]         i_stamp_ns,
    input  logic [ntm_pkg::HANDLE_W-1:0]        i_frame_handle,
    input  ntm_pkg::t_cmd                       i_cmd,
    output ntm_pkg::t_status                    o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_matched,
    output logic [ntm_pkg::HANDLE_W-1:0]        o_match_handle,
    output logic signed [ntm_pkg::OFFS_W-1:0]   o_signed_offset_ns,
    output logic [ntm_pkg::STAMP_W-1:0]         o_abs_offset_ns,
    output logic [ntm_pkg::OCC_W-1:0]           o_occupancy
);
    import ntm_pkg::*;

    // configuration
    logic [LIMIT_W-1:0]  r_limit;
    logic [STAMP_W-1:0]  r_max_off;
    logic                r_sorted;

    // buffer control
    logic [PTR_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_k;
    logic [CNT_W-1:0]    r_pos;
    logic                r_found;

    // current word
    logic [STAMP_W-1:0]  r_stamp;
    logic [HANDLE_W-1:0] r_handle;

    // frame store
    logic [WORD_W-1:0]   r_mem [RING];
    logic [WORD_W-1:0]   r_rd_word;
    logic                r_rd_vld;
    t_rd_kind            r_rd_kind;
    logic [CNT_W-1:0]    r_rd_idx;

    // match pipeline
    logic                r_d_vld;
    logic [STAMP_W-1:0]  r_d_abs;
    logic [OFFS_W-1:0]   r_d_diff;
    logic [HANDLE_W-1:0] r_d_handle;
    logic                r_best_vld;
    logic [STAMP_W-1:0]  r_near_abs;
    logic [OFFS_W-1:0]   r_best_diff;
    logic [HANDLE_W-1:0] r_best_handle;

    // result register
    logic                r_out_vld;
    logic                r_out_matched;
    logic [HANDLE_W-1:0] r_out_handle;
    logic [OFFS_W-1:0]   r_out_diff;
    logic [STAMP_W-1:0]  r_out_abs;
    logic [OCC_W-1:0]    r_out_occ;

    logic [STAMP_W-1:0]  rd_stamp;
    logic [HANDLE_W-1:0] rd_handle;
    logic [CNT_W-1:0]    rd_lidx;
    logic [PTR_W-1:0]    rd_addr;
    logic [PTR_W-1:0]    shift_addr;
    logic [PTR_W-1:0]    ins_addr;
    logic                shift_wr;
    logic [CNT_W-1:0]    lim_c;
    logic [CNT_W-1:0]    total;
    logic [CNT_W-1:0]    drop;
    logic [OFFS_W-1:0]   d_fw;
    logic [OFFS_W-1:0]   d_bw;
    logic                best_upd;
    logic                hit;
    logic                matched;

    assign rd_stamp   = r_rd_word[WORD_W-1:HANDLE_W];
    assign rd_handle  = r_rd_word[HANDLE_W-1:0];
    assign rd_lidx    = i_cmd.rd_back ? (r_k - CNT_W'(1)) : r_k;
    assign rd_addr    = ring_add(r_head, rd_lidx);
    assign shift_addr = ring_add(r_head, r_rd_idx);
    assign ins_addr   = ring_add(r_head, r_pos);
    assign shift_wr   = r_rd_vld && (r_rd_kind == RD_SHIFT);

    assign lim_c = (r_limit > LIMIT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(r_limit);
    assign total = r_count + CNT_W'(1);
    assign drop  = (total > lim_c) ? (total - lim_c) : '0;

    // both differences in parallel, sign of the forward one selects
    assign d_fw = {1'b0, rd_stamp} - {1'b0, r_stamp};
    assign d_bw = {1'b0, r_stamp} - {1'b0, rd_stamp};

    assign hit      = r_rd_vld && (r_rd_kind == RD_FIND) && !r_found && (rd_stamp > r_stamp);
    assign best_upd = r_d_vld && (!r_best_vld || (r_d_abs < r_near_abs));
    assign matched  = r_best_vld && (r_near_abs <= r_max_off);

    always_ff @(posedge i_clk) begin
        if (shift_wr) begin
            r_mem[shift_addr] <= r_rd_word;
        end else if (i_cmd.insert) begin
            r_mem[ins_addr] <= {r_stamp, r_handle};
        end
        r_rd_word <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_W'(16);
            r_max_off  <= STAMP_W'(50000000);
            r_sorted   <= 1'b0;
            r_head     <= '0;
            r_count    <= '0;
            r_k        <= '0;
            r_pos      <= '0;
            r_found    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_kind  <= RD_FIND;
            r_d_vld    <= 1'b0;
            r_best_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_LIMIT:      r_limit   <= i_cfg_wdata[LIMIT_W-1:0];
                    CFG_MAX_OFFSET: r_max_off <= i_cfg_wdata[STAMP_W-1:0];
                    CFG_SORTED:     r_sorted  <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                r_k        <= '0;
                r_found    <= 1'b0;
                r_pos      <= r_count;
                r_best_vld <= 1'b0;
            end else if (i_cmd.to_count) begin
                r_k <= r_count;
            end else if (i_cmd.rd_fwd) begin
                r_k <= r_k + CNT_W'(1);
            end else if (i_cmd.rd_back) begin
                r_k <= r_k - CNT_W'(1);
            end

            r_rd_vld  <= i_cmd.rd_fwd || i_cmd.rd_back;
            r_rd_kind <= i_cmd.rd_kind;

            // first entry with a larger stamp sets the insert point
            if (hit) begin
                r_found <= 1'b1;
                r_pos   <= r_rd_idx;
            end

            r_d_vld <= r_rd_vld && (r_rd_kind == RD_MATCH);
            if (best_upd) begin
                r_best_vld <= 1'b1;
            end

            if (i_cmd.insert) begin
                r_count <= total - drop;
                r_head  <= ring_add(r_head, drop);
            end else if (i_cmd.clear) begin
                r_count <= '0;
            end

            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_stamp  <= i_stamp_ns;
            r_handle <= i_frame_handle;
        end
        r_rd_idx   <= r_k;
        r_d_abs    <= d_fw[OFFS_W-1] ? d_bw[STAMP_W-1:0] : d_fw[STAMP_W-1:0];
        r_d_diff   <= d_fw;
        r_d_handle <= rd_handle;
        if (best_upd) begin
            r_near_abs    <= r_d_abs;
            r_best_diff   <= r_d_diff;
            r_best_handle <= r_d_handle;
        end
        if (i_cmd.out_load) begin
            r_out_matched <= matched;
            r_out_handle  <= matched ? r_best_handle : '0;
            r_out_diff    <= matched ? r_best_diff : '0;
            r_out_abs     <= matched ? r_near_abs : '0;
            r_out_occ     <= OCC_W'(r_count);
        end
    end

    assign o_status.sorted     = r_sorted;
    assign o_status.k_lt_count = r_k < r_count;
    assign o_status.k_gt_pos   = r_k > r_pos;
    assign o_status.found      = r_found;
    assign o_status.busy       = r_rd_vld || r_d_vld;
    assign o_status.out_busy   = r_out_vld && !i_out_ready;

    assign o_out_valid        = r_out_vld;
    assign o_matched          = r_out_matched;
    assign o_match_handle     = r_out_handle;
    assign o_signed_offset_ns = r_out_diff;
    assign o_abs_offset_ns    = r_out_abs;
    assign o_occupancy        = r_out_occ;

    `NTM_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH), "buffer count out of range")
    `NTM_ASSERT_IMPL(a_head_bound, 1'b1, r_head < PTR_W'(RING), "buffer head out of range")
    `NTM_ASSERT_IMPL(a_write_clash, shift_wr, !i_cmd.insert, "shift write collides with insert")
    `NTM_ASSERT_NEXT(a_match_stage, r_rd_vld && (r_rd_kind == RD_MATCH), r_d_vld, "match read lost")
    `NTM_ASSERT_NEXT(a_insert_trim, i_cmd.insert, r_count <= $past(lim_c), "count above limit")

endmodule

// ===== sv/nearest_timestamp_matcher_top.sv =====
// nearest timestamp matcher top level: state machine plus ring buffer datapath
// push: find, find drain, shift, shift drain, insert; sorted mode reads frames to find and shift
// match: scans the buffer with one read per frame, then loads the result word
// clear: a single state; one word in work at a time, a pending result word holds a match in its last state
// reset (synchronous, active low) empties the buffer and loads the register defaults
module nearest_timestamp_matcher_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ntm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ntm_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ntm_pkg::OP_W-1:0]            i_op,
    input  logic [ntm_pkg::STAMP_W-1:0]         i_stamp_ns,
    input  logic [ntm_pkg::HANDLE_W-1:0]        i_frame_handle,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_matched,
    output logic [ntm_pkg::HANDLE_W-1:0]        o_match_handle,
    output logic signed [ntm_pkg::OFFS_W-1:0]   o_signed_offset_ns,
    output logic [ntm_pkg::STAMP_W-1:0]         o_abs_offset_ns,
    output logic [ntm_pkg::OCC_W-1:0]           o_occupancy
);
    import ntm_pkg::*;

    t_cmd    cmd;
    t_status status;

    ntm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ntm_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_stamp_ns         (i_stamp_ns),
        .i_frame_handle     (i_frame_handle),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_matched          (o_matched),
        .o_match_handle     (o_match_handle),
        .o_signed_offset_ns (o_signed_offset_ns),
        .o_abs_offset_ns    (o_abs_offset_ns),
        .o_occupancy        (o_occupancy)
    );

endmodule

// ===== verif/nearest_timestamp_matcher_top_tb.sv =====
// testbench for the nearest timestamp matcher: directed and random words against a scoreboard
`timescale 1ns / 100ps

module nearest_timestamp_matcher_top_tb;
    import ntm_pkg::*;

    localparam logic [OP_W-1:0]    OP_UNUSED   = 2'd3;
    localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;
    localparam int                 PHASES      = 16;
    localparam int                 PHASE_WORDS = 106;
    localparam int                 SETTLE      = 64;
    localparam int unsigned        CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic                       matched;
        logic [HANDLE_W-1:0]        handle;
        logic signed [OFFS_W-1:0]   soffs;
        logic [STAMP_W-1:0]         aoffs;
        logic [OCC_W-1:0]           occ;
    } t_match_word;

    class match_scoreboard;
        logic [STAMP_W-1:0]  stamps [DEPTH];
        logic [HANDLE_W-1:0] handles [DEPTH];
        int                  count;
        logic [LIMIT_W-1:0]  limit;
        logic [STAMP_W-1:0]  max_offset;
        logic                sorted;
        t_match_word         pending [$];
        int unsigned         fail_count;

        function new();
            count      = 0;
            limit      = 5'd16;
            max_offset = 63'd50000000;
            sorted     = 1'b0;
            fail_count = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_LIMIT:      limit = data[LIMIT_W-1:0];
                CFG_MAX_OFFSET: max_offset = data[STAMP_W-1:0];
                CFG_SORTED:     sorted = data[0];
                default: ;
            endcase
        endfunction

        function void insert_frame(logic [STAMP_W-1:0] stamp, logic [HANDLE_W-1:0] handle);
            logic [STAMP_W-1:0]  s [DEPTH+1];
            logic [HANDLE_W-1:0] h [DEPTH+1];
            int pos, k, total, keep, drop;
            pos = count;
            if (sorted) begin
                for (int i = 0; i < count; i++) begin
                    if (stamps[i] > stamp) begin
                        pos = i;
                        break;
                    end
                end
            end
            k = 0;
            for (int i = 0; i <= count; i++) begin
                if (i == pos) begin
                    s[i] = stamp;
                    h[i] = handle;
                end else begin
                    s[i] = stamps[k];
                    h[i] = handles[k];
                    k++;
                end
            end
            total = count + 1;
            keep  = (int'(limit) > DEPTH) ? DEPTH : int'(limit);
            drop  = (total > keep) ? total - keep : 0;
            for (int i = drop; i < total; i++) begin
                stamps[i-drop]  = s[i];
                handles[i-drop] = h[i];
            end
            count = total - drop;
        endfunction

        function t_match_word nearest_frame(logic [STAMP_W-1:0] q);
            t_match_word        r;
            logic [STAMP_W-1:0] a, near_abs;
            int                 best;
            logic               found;
            r        = '0;
            r.occ    = OCC_W'(count);
            best     = 0;
            near_abs = '0;
            found    = 1'b0;
            for (int i = 0; i < count; i++) begin
                a = (stamps[i] >= q) ? stamps[i] - q : q - stamps[i];
                if (!found || a < near_abs) begin
                    found    = 1'b1;
                    near_abs = a;
                    best     = i;
                end
            end
            if (found && near_abs <= max_offset) begin
                r.matched = 1'b1;
                r.handle  = handles[best];
                r.soffs   = {1'b0, stamps[best]} - {1'b0, q};
                r.aoffs   = near_abs;
            end
            return r;
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic [STAMP_W-1:0] stamp,
                                logic [HANDLE_W-1:0] handle);
            case (op)
                OP_PUSH:  insert_frame(stamp, handle);
                OP_MATCH: pending.insert(pending.size(), nearest_frame(stamp));
                OP_CLEAR: count = 0;
                default: ;
            endcase
        endfunction

        function void note_failure(string msg);
            fail_count++;
            if (fail_count <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void check_result(t_match_word got);
            t_match_word want;
            if (pending.size() == 0) begin
                note_failure($sformatf("unexpected result word: matched=%0d handle=%h occ=%0d",
                                       got.matched, got.handle, got.occ));
                return;
            end
            want = pending[0];
            pending.delete(0);
            if (got.matched !== want.matched || got.handle !== want.handle ||
                got.soffs !== want.soffs || got.aoffs !== want.aoffs || got.occ !== want.occ) begin
                note_failure($sformatf({"result mismatch: expected %0d/%h/%0d/%0d/%0d",
                                        " got %0d/%h/%0d/%0d/%0d"},
                                       want.matched, want.handle, want.soffs, want.aoffs, want.occ,
                                       got.matched, got.handle, got.soffs, got.aoffs, got.occ));
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_W-1:0]             i_cfg_wdata;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [OP_W-1:0]              i_op;
    logic [STAMP_W-1:0]           i_stamp_ns;
    logic [HANDLE_W-1:0]          i_frame_handle;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic                         o_matched;
    logic [HANDLE_W-1:0]          o_match_handle;
    logic signed [OFFS_W-1:0]     o_signed_offset_ns;
    logic [STAMP_W-1:0]           o_abs_offset_ns;
    logic [OCC_W-1:0]             o_occupancy;

    match_scoreboard sb;
    bit              gaps_on;
    int              stall_left;
    int unsigned     cycle_count;

    nearest_timestamp_matcher_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_stamp_ns         (i_stamp_ns),
        .i_frame_handle     (i_frame_handle),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_matched          (o_matched),
        .o_match_handle     (o_match_handle),
        .o_signed_offset_ns (o_signed_offset_ns),
        .o_abs_offset_ns    (o_abs_offset_ns),
        .o_occupancy        (o_occupancy)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: check accepted words, stall in short bursts
    always @(posedge i_clk) begin
        t_match_word got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.matched = o_matched;
            got.handle  = o_match_handle;
            got.soffs   = o_signed_offset_ns;
            got.aoffs   = o_abs_offset_ns;
            got.occ     = o_occupancy;
            sb.check_result(got);
        end
        if (stall_left > 0) begin
            stall_left  = stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left  = $urandom_range(1, 3) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic [STAMP_W-1:0] rand_stamp();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[STAMP_W-1:0];
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [STAMP_W-1:0] stamp,
                             input logic [HANDLE_W-1:0] handle);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_stamp_ns     <= stamp;
        i_frame_handle <= handle;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_word(op, stamp, handle);
    endtask

    task automatic load_settings(input logic [LIMIT_W-1:0] limit,
                                 input logic [STAMP_W-1:0] max_off, input logic sorted);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_LIMIT;
        i_cfg_wdata <= CFG_W'(limit);
        sb.set_reg(CFG_LIMIT, CFG_W'(limit));
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_OFFSET;
        i_cfg_wdata <= max_off;
        sb.set_reg(CFG_MAX_OFFSET, max_off);
        @(posedge i_clk);
        i_cfg_index <= CFG_SORTED;
        i_cfg_wdata <= CFG_W'(sorted);
        sb.set_reg(CFG_SORTED, CFG_W'(sorted));
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin : main
        logic [63:0]          r64;
        logic [STAMP_W-1:0]   period, base, span, max_off, stamp;
        logic [LIMIT_W-1:0]   limit;
        logic                 sorted;
        logic [OP_W-1:0]      op;
        int                   pick;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = CFG_LIMIT;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_op           = OP_PUSH;
        i_stamp_ns     = '0;
        i_frame_handle = '0;
        i_out_ready    = 1'b0;
        stall_left     = 0;
        cycle_count    = 0;
        gaps_on        = 1'b1;
        sb             = new();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at the reset settings
        send_word(OP_MATCH, 63'd0, 32'h0);
        send_word(OP_PUSH, 63'd0, 32'h0);
        send_word(OP_PUSH, STAMP_MAX, 32'hFFFF_FFFF);
        send_word(OP_MATCH, STAMP_MAX, 32'h1234_5678);
        send_word(OP_MATCH, 63'd0, 32'h0);
        send_word(OP_MATCH, 63'h4000_0000_0000_0000, 32'h0);
        send_word(OP_CLEAR, 63'd0, 32'h0);
        send_word(OP_MATCH, 63'd1000, 32'h0);
        send_word(OP_PUSH, 63'd1000, 32'hAAAA_0001);
        send_word(OP_PUSH, 63'd1000, 32'hBBBB_0002);
        send_word(OP_PUSH, 63'd3000, 32'hCCCC_0003);
        send_word(OP_MATCH, 63'd2000, 32'h0);
        send_word(OP_MATCH, 63'd1000, 32'h0);
        send_word(OP_MATCH, 63'd50003000, 32'h0);
        send_word(OP_MATCH, 63'd50003001, 32'h0);
        send_word(OP_UNUSED, 63'd2500, 32'hDEAD_BEEF);
        send_word(OP_MATCH, 63'd2500, 32'h0);
        send_word(OP_MATCH, 63'd0, 32'h0);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            gaps_on = (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);

            case ($urandom_range(0, 3))
                0: period = 63'($urandom_range(1, 4));
                1: period = 63'd33333333;
                2: period = 63'($urandom) + 63'd1;
                default: begin
                    r64    = {$urandom, $urandom};
                    period = 63'(r64[55:0]) | 63'd1;
                end
            endcase
            span = period * 63'd40;
            case ($urandom_range(0, 2))
                0: base = '0;
                1: base = STAMP_MAX - span;
                default: base = rand_stamp() >> 1;
            endcase

            case ($urandom_range(0, 3))
                0: max_off = '0;
                1: max_off = STAMP_MAX;
                2: max_off = (period * 63'($urandom_range(0, 3))) >> 1;
                default: max_off = rand_stamp();
            endcase
            sorted = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0) begin
                limit = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
            end else begin
                limit = 5'($urandom_range(1, 16));
            end
            case (ph)
                0: begin limit = 5'd16; max_off = STAMP_MAX; sorted = 1'b0; end
                1: begin limit = 5'd2;  max_off = STAMP_MAX; sorted = 1'b1; end
                2: begin limit = 5'd0;  sorted = 1'b0; end
                3: begin limit = 5'd31; max_off = '0; sorted = 1'b1; end
                4: begin limit = 5'd1;  sorted = 1'b0; end
                5: begin limit = 5'd16; sorted = 1'b1; end
                default: ;
            endcase
            load_settings(limit, max_off, sorted);

            // look at what the last phase left behind
            send_word(OP_MATCH, base + (span >> 1), $urandom);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 52) op = OP_PUSH;
                else if (pick < 92) op = OP_MATCH;
                else if (pick < 96) op = OP_CLEAR;
                else op = OP_UNUSED;
                if ($urandom_range(0, 9) == 0) begin
                    stamp = rand_stamp();
                end else if (op == OP_PUSH) begin
                    stamp = base + period * 63'($urandom_range(0, 40));
                end else begin
                    stamp = base + ((period * 63'($urandom_range(0, 80))) >> 1);
                end
                send_word(op, stamp, $urandom);
            end
            wait_drained();
        end

        if (sb.fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
